FILE: rtl/core/assert_macros.svh
// assertion macros shared by the contrast ratio rtl
// clocked on the rising edge, disabled while the synchronous reset is active
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SCR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property must hold at every clock edge
`define SCR_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/srgb_cr_pkg.sv
// shared types, constants and the srgb linearization table for the contrast ratio block
// no dependencies
`default_nettype none

package srgb_cr_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned LIN_W       = FRAC_BITS + 1;
  localparam int unsigned TERM_W      = 17;
  localparam int unsigned QUO_W       = 21;
  localparam int unsigned NUM_W       = TERM_W + FRAC_BITS;
  localparam int unsigned PROD_W      = LIN_W + WEIGHT_BITS;
  localparam int unsigned SUM_W       = PROD_W + 2;
  localparam int unsigned LANE_STAGES = 3;
  localparam int unsigned DIV_STEP_BITS = 3;
  localparam int unsigned DIV_STAGES  = QUO_W / DIV_STEP_BITS;
  localparam int unsigned LATENCY     = LANE_STAGES + DIV_STAGES;

  localparam logic [WEIGHT_BITS-1:0] W_RED   = WEIGHT_BITS'(13933);
  localparam logic [WEIGHT_BITS-1:0] W_GREEN = WEIGHT_BITS'(46871);
  localparam logic [WEIGHT_BITS-1:0] W_BLUE  = WEIGHT_BITS'(4732);
  localparam logic [SUM_W-1:0]       ROUND_HALF = SUM_W'(64'd1 << (WEIGHT_BITS - 1));
  localparam logic [TERM_W-1:0]      OFFSET =
    TERM_W'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);

  typedef logic [TERM_W-1:0] term_t;
  typedef logic [LIN_W-1:0]  lin_t;

  typedef struct packed {
    logic [CHAN_W-1:0] first_red;
    logic [CHAN_W-1:0] first_green;
    logic [CHAN_W-1:0] first_blue;
    logic [CHAN_W-1:0] second_red;
    logic [CHAN_W-1:0] second_green;
    logic [CHAN_W-1:0] second_blue;
  } in_item_t;

  typedef struct packed {
    term_t              first_term;
    term_t              second_term;
    logic [QUO_W-1:0]   contrast_ratio;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

  // partial long division carried down the divider stages
  typedef struct packed {
    term_t             dividend;
    term_t             divisor;
    logic [TERM_W-1:0] rem;
    logic [QUO_W-1:0]  rest;
    logic [QUO_W-1:0]  quo;
  } div_state_t;

  typedef logic [(1 << CHAN_W)-1:0][LIN_W-1:0] lin_tab_t;

  // one table entry: linear segment for dark codes, else q31 power 2.4 via fifth root
  function automatic lin_t lin_entry(input int unsigned v);
    logic [63:0] x;
    logic [63:0] z;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] t2;
    logic [63:0] t4;
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] vv;
    vv = 64'(v);
    if (vv * 64'd100000 < 64'd1001640) begin
      return LIN_W'((((vv * 64'd10) << FRAC_BITS) + 64'd16473) / 64'd32946);
    end
    x  = ((vv * 64'd1000 + 64'd14025) << 31) / 64'd269025;
    z  = (x * x) >> 31;
    lo = 64'd0;
    hi = 64'd1 << 31;
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        t2  = (mid * mid) >> 31;
        t4  = (t2 * t2) >> 31;
        p   = (t4 * mid) >> 31;
        if (p <= z) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    y = (z * lo) >> 31;
    return LIN_W'((y + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int v = 0; v < (1 << CHAN_W); v++) begin
      tab[v] = lin_entry(v);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

`default_nettype wire

FILE: rtl/core/srgb_cr_lane.sv
// one color lane: table lookup, weighted products, rounded sum plus offset
// depends on srgb_cr_pkg
`default_nettype none

module srgb_cr_lane (
  input  wire logic                clk,
  input  wire srgb_cr_pkg::color_t color,
  output srgb_cr_pkg::term_t       term
);

  srgb_cr_pkg::lin_t lin_red_r, lin_green_r, lin_blue_r;
  srgb_cr_pkg::lin_t lin_red_nxt, lin_green_nxt, lin_blue_nxt;
  logic [srgb_cr_pkg::PROD_W-1:0] prod_red_r, prod_green_r, prod_blue_r;
  logic [srgb_cr_pkg::PROD_W-1:0] prod_red_nxt, prod_green_nxt, prod_blue_nxt;
  logic [srgb_cr_pkg::SUM_W-1:0]  sum_w;
  srgb_cr_pkg::term_t term_r, term_nxt;

  always_comb begin
    lin_red_nxt   = srgb_cr_pkg::LIN_TAB[color.red];
    lin_green_nxt = srgb_cr_pkg::LIN_TAB[color.green];
    lin_blue_nxt  = srgb_cr_pkg::LIN_TAB[color.blue];
  end

  always_comb begin
    prod_red_nxt   = srgb_cr_pkg::PROD_W'(lin_red_r)
                   * srgb_cr_pkg::PROD_W'(srgb_cr_pkg::W_RED);
    prod_green_nxt = srgb_cr_pkg::PROD_W'(lin_green_r)
                   * srgb_cr_pkg::PROD_W'(srgb_cr_pkg::W_GREEN);
    prod_blue_nxt  = srgb_cr_pkg::PROD_W'(lin_blue_r)
                   * srgb_cr_pkg::PROD_W'(srgb_cr_pkg::W_BLUE);
  end

  // round to FRAC_BITS, then add the 0.05 offset
  always_comb begin
    sum_w = srgb_cr_pkg::SUM_W'(prod_red_r) + srgb_cr_pkg::SUM_W'(prod_green_r)
          + srgb_cr_pkg::SUM_W'(prod_blue_r) + srgb_cr_pkg::ROUND_HALF;
    term_nxt = srgb_cr_pkg::TERM_W'(sum_w >> srgb_cr_pkg::WEIGHT_BITS)
             + srgb_cr_pkg::OFFSET;
  end

  always_ff @(posedge clk) begin
    lin_red_r    <= lin_red_nxt;
    lin_green_r  <= lin_green_nxt;
    lin_blue_r   <= lin_blue_nxt;
    prod_red_r   <= prod_red_nxt;
    prod_green_r <= prod_green_nxt;
    prod_blue_r  <= prod_blue_nxt;
    term_r       <= term_nxt;
  end

  assign term = term_r;

endmodule

`default_nettype wire

FILE: rtl/core/srgb_cr_div_stage.sv
// one restoring divider stage, resolves DIV_STEP_BITS quotient bits per cycle
// depends on srgb_cr_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module srgb_cr_div_stage (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire srgb_cr_pkg::div_state_t in_st,
  output logic                         out_valid,
  output srgb_cr_pkg::div_state_t      out_st
);

  logic                    valid_r;
  srgb_cr_pkg::div_state_t st_r, st_nxt;

  always_comb begin
    logic [srgb_cr_pkg::TERM_W:0] shifted;
    logic [srgb_cr_pkg::TERM_W:0] divisor_x;
    logic                         q_bit;
    st_nxt = in_st;
    for (int k = 0; k < srgb_cr_pkg::DIV_STEP_BITS; k++) begin
      shifted   = {st_nxt.rem, st_nxt.rest[srgb_cr_pkg::QUO_W-1]};
      divisor_x = {1'b0, st_nxt.divisor};
      q_bit     = (shifted >= divisor_x);
      if (q_bit) begin
        shifted = shifted - divisor_x;
      end
      st_nxt.rem  = shifted[srgb_cr_pkg::TERM_W-1:0];
      st_nxt.rest = {st_nxt.rest[srgb_cr_pkg::QUO_W-2:0], 1'b0};
      st_nxt.quo  = {st_nxt.quo[srgb_cr_pkg::QUO_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

  // partial remainder must stay below the divisor after every stage
  `SCR_ASSERT_IMP(a_rem_below_divisor, clk, rst_n, valid_r, st_r.rem < st_r.divisor, "divider remainder not below divisor")

endmodule

`default_nettype wire

FILE: rtl/core/srgb_contrast_ratio_top.sv
// top level of the srgb contrast ratio block: two color lanes and a pipelined divider
// depends on srgb_cr_pkg, srgb_cr_lane, srgb_cr_div_stage and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

// usage
// - input: a color pair transfers at a rising edge with start high and busy low;
//   busy is held low, so a new pair may be sent every cycle
// - each channel goes through a constant 256-entry linearization table, then
//   the weighted sum plus the 0.05 offset gives first_term and second_term
// - contrast_ratio is first_term / second_term with 16 fraction bits, truncated;
//   the colors are taken in the order given, never swapped by brightness
// - pipeline: the lane registers lookup, multiply and sum, then 7 divider stages
//   of 3 quotient bits each
// - throughput: one pair per cycle, every stage is a plain pipeline register
// - output: out_valid marks a result for exactly one cycle; the receiver
//   cannot stall, so every result is taken at the edge that ends that cycle
// - reset: synchronous active low rst_n clears all valid bits, in-flight
//   pairs are dropped and no strobe is raised until new pairs arrive
// - no configuration registers and no state linking consecutive pairs
module srgb_contrast_ratio_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire srgb_cr_pkg::in_item_t in_item,
  output logic                       out_valid,
  output srgb_cr_pkg::out_item_t     out_item
);

  localparam int unsigned CHK_W = srgb_cr_pkg::QUO_W + srgb_cr_pkg::TERM_W;

  logic                            in_xfer;
  logic [srgb_cr_pkg::LANE_STAGES-1:0] lane_vld_r, lane_vld_nxt;
  srgb_cr_pkg::color_t             first_color, second_color;
  srgb_cr_pkg::term_t              first_term_w, second_term_w;
  logic [srgb_cr_pkg::NUM_W-1:0]   numer_w;
  srgb_cr_pkg::div_state_t         div_st_w  [srgb_cr_pkg::DIV_STAGES+1];
  logic                            div_vld_w [srgb_cr_pkg::DIV_STAGES+1];

  // the block never holds off a transfer
  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  // split the pair into one color per lane
  always_comb begin
    first_color.red    = in_item.first_red;
    first_color.green  = in_item.first_green;
    first_color.blue   = in_item.first_blue;
    second_color.red   = in_item.second_red;
    second_color.green = in_item.second_green;
    second_color.blue  = in_item.second_blue;
  end

  srgb_cr_lane u_lane_first (
    .clk   (clk),
    .color (first_color),
    .term  (first_term_w)
  );

  srgb_cr_lane u_lane_second (
    .clk   (clk),
    .color (second_color),
    .term  (second_term_w)
  );

  // valid bits track the lane pipeline, the lanes themselves carry no control
  assign lane_vld_nxt = {lane_vld_r[srgb_cr_pkg::LANE_STAGES-2:0], in_xfer};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_vld_r <= '0;
    end else begin
      lane_vld_r <= lane_vld_nxt;
    end
  end

  // merge: numerator first_term << FRAC_BITS; the top bits already sit below
  // the divisor since first_term is under 21 times the offset
  assign numer_w = {first_term_w, srgb_cr_pkg::FRAC_BITS'(0)};

  always_comb begin
    div_st_w[0].dividend = first_term_w;
    div_st_w[0].divisor  = second_term_w;
    div_st_w[0].rem      = srgb_cr_pkg::TERM_W'(numer_w[srgb_cr_pkg::NUM_W-1:srgb_cr_pkg::QUO_W]);
    div_st_w[0].rest     = numer_w[srgb_cr_pkg::QUO_W-1:0];
    div_st_w[0].quo      = '0;
    div_vld_w[0]         = lane_vld_r[srgb_cr_pkg::LANE_STAGES-1];
  end

  for (genvar s = 0; s < srgb_cr_pkg::DIV_STAGES; s++) begin : g_div
    srgb_cr_div_stage u_div_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_vld_w[s]),
      .in_st     (div_st_w[s]),
      .out_valid (div_vld_w[s+1]),
      .out_st    (div_st_w[s+1])
    );
  end

  // result transfer straight from the last divider stage register
  always_comb begin
    out_valid               = div_vld_w[srgb_cr_pkg::DIV_STAGES];
    out_item.first_term     = div_st_w[srgb_cr_pkg::DIV_STAGES].dividend;
    out_item.second_term    = div_st_w[srgb_cr_pkg::DIV_STAGES].divisor;
    out_item.contrast_ratio = div_st_w[srgb_cr_pkg::DIV_STAGES].quo;
  end

  // every result comes from a matching input transfer through the lane and divider registers
  `SCR_ASSERT_IMP(a_out_latency, clk, rst_n, out_valid, $past(in_xfer, srgb_cr_pkg::LATENCY), "result without matching input transfer")

  // both terms carry at least the offset
  `SCR_ASSERT_ALWAYS(a_terms_floor, clk, rst_n, !out_valid || (out_item.first_term >= srgb_cr_pkg::OFFSET && out_item.second_term >= srgb_cr_pkg::OFFSET), "term below offset")

  // quotient is the truncated division: q*d <= n < (q+1)*d
  `SCR_ASSERT_IMP(a_ratio_exact, clk, rst_n, out_valid, (CHK_W'(out_item.contrast_ratio) * CHK_W'(out_item.second_term) <= (CHK_W'(out_item.first_term) << srgb_cr_pkg::FRAC_BITS)) && ((CHK_W'(out_item.contrast_ratio) + CHK_W'(1)) * CHK_W'(out_item.second_term) > (CHK_W'(out_item.first_term) << srgb_cr_pkg::FRAC_BITS)), "contrast ratio is not the truncated quotient")

endmodule

`default_nettype wire
